FILE: hdl/chs_pkg.sv
// Shared constants, types and arithmetic helpers for the cosine hemisphere sampler.
package chs_pkg;

    // Pipeline layout: stage 0 registers the input transaction, the square roots
    // and the sine/cosine series share stages 1 onward, the scaling takes the last two.
    localparam int SQ_STAGES         = 4;
    localparam int SQ_STEPS          = 4;
    localparam int TRIG_STAGES       = 10;
    localparam int SCALE_STAGES      = 2;
    localparam int STAGE_SQRT_LAST   = SQ_STAGES;
    localparam int STAGE_TRIG_LAST   = TRIG_STAGES;
    localparam int STAGE_SCALE_FIRST = TRIG_STAGES + 1;
    localparam int NUM_STAGES        = STAGE_SCALE_FIRST + SCALE_STAGES;

    // Quadrant codes of the angle, in quarter turns.
    localparam logic [1:0] QUAD_EAST  = 2'd0;
    localparam logic [1:0] QUAD_NORTH = 2'd1;
    localparam logic [1:0] QUAD_WEST  = 2'd2;
    localparam logic [1:0] QUAD_SOUTH = 2'd3;

    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam logic [45:0] HALF_Q30   = 46'h0000_2000_0000;
    localparam logic [15:0] SAT_LIM    = 16'd32767;

    // Exact reciprocals: floor(p / k) = (p * M) >> SH for every p below 2^31,
    // with SH = 31 + ceil(log2(k)) and M = ceil(2^SH / k).
    localparam int unsigned DIV72_SH = 38;
    localparam int unsigned DIV90_SH = 38;
    localparam int unsigned DIV42_SH = 37;
    localparam int unsigned DIV56_SH = 37;
    localparam int unsigned DIV20_SH = 36;
    localparam int unsigned DIV30_SH = 36;
    localparam int unsigned DIV6_SH  = 34;
    localparam int unsigned DIV12_SH = 35;
    localparam logic [31:0] DIV72_M = 32'(((64'd1 << 38) + 64'd71) / 64'd72);
    localparam logic [31:0] DIV90_M = 32'(((64'd1 << 38) + 64'd89) / 64'd90);
    localparam logic [31:0] DIV42_M = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
    localparam logic [31:0] DIV56_M = 32'(((64'd1 << 37) + 64'd55) / 64'd56);
    localparam logic [31:0] DIV20_M = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
    localparam logic [31:0] DIV30_M = 32'(((64'd1 << 36) + 64'd29) / 64'd30);
    localparam logic [31:0] DIV6_M  = 32'(((64'd1 << 34) + 64'd5) / 64'd6);
    localparam logic [31:0] DIV12_M = 32'(((64'd1 << 35) + 64'd11) / 64'd12);

    typedef struct packed {
        logic [29:0] sin_mag;
        logic [30:0] cos_mag;
        logic [1:0]  quad;
        logic        neg;
    } trig_t;

    // Q30 product of a value below 2^30 and a value of at most 2^30.
    function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
        logic [60:0] prod;
        prod = 61'(a) * 61'(b);
        return prod[59:30];
    endfunction

    // Quotient by a small constant through its reciprocal.
    function automatic logic [29:0] mul_recip(input logic [29:0] p, input logic [31:0] m,
                                              input int unsigned sh);
        logic [61:0] prod;
        prod = 62'(p) * 62'(m);
        return 30'(prod >> sh);
    endfunction

endpackage

FILE: hdl/chs_isqrt.sv
// Pipelined integer square root, four result bits per register stage.
module chs_isqrt (
    input  logic                          aclk,
    input  logic [chs_pkg::SQ_STAGES-1:0] stage_en,
    input  logic [31:0]                   value,
    output logic [15:0]                   root
);

    localparam int LAST  = chs_pkg::SQ_STAGES - 1;
    localparam int PAIRS = chs_pkg::SQ_STAGES * chs_pkg::SQ_STEPS;

    typedef struct packed {
        logic [17:0] rem;
        logic [15:0] root;
    } sq_acc_t;

    function automatic sq_acc_t sq_step(input sq_acc_t acc, input logic [1:0] pair);
        logic [19:0] cur;
        logic [19:0] trial;
        sq_acc_t     res;
        cur   = {acc.rem, pair};
        trial = {2'b00, acc.root, 2'b01};
        if (cur >= trial) begin
            res.rem  = 18'(cur - trial);
            res.root = {acc.root[14:0], 1'b1};
        end else begin
            res.rem  = cur[17:0];
            res.root = {acc.root[14:0], 1'b0};
        end
        return res;
    endfunction

    sq_acc_t     acc_in   [chs_pkg::SQ_STAGES];
    logic [31:0] val_in   [chs_pkg::SQ_STAGES];
    sq_acc_t     acc_next [chs_pkg::SQ_STAGES];
    sq_acc_t     acc_reg  [LAST];
    logic [31:0] val_reg  [LAST];
    logic [15:0] root_reg;

    for (genvar k = 0; k < chs_pkg::SQ_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign acc_in[k] = '0;
            assign val_in[k] = value;
        end else begin : g_next
            assign acc_in[k] = acc_reg[k-1];
            assign val_in[k] = val_reg[k-1];
        end

        always_comb begin : step
            sq_acc_t a;
            a = acc_in[k];
            for (int i = 0; i < chs_pkg::SQ_STEPS; i++) begin
                a = sq_step(a, val_in[k][2*(PAIRS-1-(k*chs_pkg::SQ_STEPS+i)) +: 2]);
            end
            acc_next[k] = a;
        end

        if (k < LAST) begin : g_reg
            always_ff @(posedge aclk) begin
                if (stage_en[k]) begin
                    acc_reg[k] <= acc_next[k];
                    val_reg[k] <= val_in[k];
                end
            end
        end else begin : g_out
            always_ff @(posedge aclk) begin
                if (stage_en[k]) begin
                    root_reg <= acc_next[k].root;
                end
            end
        end
    end

    assign root = root_reg;

endmodule

FILE: hdl/chs_sincos.sv
// Pipelined quadrant reduction and Q30 Taylor series for sine and cosine.
module chs_sincos (
    input  logic                            aclk,
    input  logic [chs_pkg::TRIG_STAGES-1:0] stage_en,
    input  logic [15:0]                     angle,
    output chs_pkg::trig_t                  trig
);

    localparam int N = chs_pkg::TRIG_STAGES;

    logic [29:0] t_reg   [N];
    logic [29:0] t2_reg  [N];
    logic [1:0]  q_reg   [N];
    logic        neg_reg [N];
    logic [30:0] sv_reg  [N];
    logic [30:0] cv_reg  [N];

    logic [29:0] t_next   [N];
    logic [29:0] t2_next  [N];
    logic [1:0]  q_next   [N];
    logic        neg_next [N];
    logic [30:0] sv_next  [N];
    logic [30:0] cv_next  [N];

    logic [16:0] round_sum;
    logic [15:0] resid;
    logic [15:0] resid_mag;
    logic [45:0] turn_prod;

    always_comb begin
        // The nearest quarter turn comes out; the residual is within an eighth turn.
        round_sum = {1'b0, angle} + 17'd8192;
        q_next[0] = round_sum[15:14];
        resid     = angle - {q_next[0], 14'd0};
        neg_next[0] = resid[15];
        resid_mag = resid[15] ? (16'd0 - resid) : resid;
        turn_prod = 46'(resid_mag[13:0]) * 46'(chs_pkg::TWO_PI_Q29);
        t_next[0]  = turn_prod[44:15];
        t2_next[0] = '0;
        sv_next[0] = '0;
        cv_next[0] = '0;

        for (int j = 1; j < N; j++) begin
            t_next[j]   = t_reg[j-1];
            t2_next[j]  = t2_reg[j-1];
            q_next[j]   = q_reg[j-1];
            neg_next[j] = neg_reg[j-1];
            sv_next[j]  = sv_reg[j-1];
            cv_next[j]  = cv_reg[j-1];
        end

        t2_next[1] = chs_pkg::mul_q30(t_reg[0], {1'b0, t_reg[0]});

        // Horner nesting: even stages divide by the term constant, odd multiply by t^2 or t.
        sv_next[2] = chs_pkg::ONE_Q30 - 31'(chs_pkg::mul_recip(t2_reg[1],
                         chs_pkg::DIV72_M, chs_pkg::DIV72_SH));
        cv_next[2] = chs_pkg::ONE_Q30 - 31'(chs_pkg::mul_recip(t2_reg[1],
                         chs_pkg::DIV90_M, chs_pkg::DIV90_SH));
        sv_next[3] = 31'(chs_pkg::mul_q30(t2_reg[2], sv_reg[2]));
        cv_next[3] = 31'(chs_pkg::mul_q30(t2_reg[2], cv_reg[2]));
        sv_next[4] = chs_pkg::ONE_Q30 - 31'(chs_pkg::mul_recip(sv_reg[3][29:0],
                         chs_pkg::DIV42_M, chs_pkg::DIV42_SH));
        cv_next[4] = chs_pkg::ONE_Q30 - 31'(chs_pkg::mul_recip(cv_reg[3][29:0],
                         chs_pkg::DIV56_M, chs_pkg::DIV56_SH));
        sv_next[5] = 31'(chs_pkg::mul_q30(t2_reg[4], sv_reg[4]));
        cv_next[5] = 31'(chs_pkg::mul_q30(t2_reg[4], cv_reg[4]));
        sv_next[6] = chs_pkg::ONE_Q30 - 31'(chs_pkg::mul_recip(sv_reg[5][29:0],
                         chs_pkg::DIV20_M, chs_pkg::DIV20_SH));
        cv_next[6] = chs_pkg::ONE_Q30 - 31'(chs_pkg::mul_recip(cv_reg[5][29:0],
                         chs_pkg::DIV30_M, chs_pkg::DIV30_SH));
        sv_next[7] = 31'(chs_pkg::mul_q30(t2_reg[6], sv_reg[6]));
        cv_next[7] = 31'(chs_pkg::mul_q30(t2_reg[6], cv_reg[6]));
        sv_next[8] = chs_pkg::ONE_Q30 - 31'(chs_pkg::mul_recip(sv_reg[7][29:0],
                         chs_pkg::DIV6_M, chs_pkg::DIV6_SH));
        cv_next[8] = chs_pkg::ONE_Q30 - 31'(chs_pkg::mul_recip(cv_reg[7][29:0],
                         chs_pkg::DIV12_M, chs_pkg::DIV12_SH));
        sv_next[9] = 31'(chs_pkg::mul_q30(t_reg[8], sv_reg[8]));
        cv_next[9] = chs_pkg::ONE_Q30
                   - 31'(chs_pkg::mul_q30(t2_reg[8], cv_reg[8]) >> 1);
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < N; j++) begin
            if (stage_en[j]) begin
                t_reg[j]   <= t_next[j];
                t2_reg[j]  <= t2_next[j];
                q_reg[j]   <= q_next[j];
                neg_reg[j] <= neg_next[j];
                sv_reg[j]  <= sv_next[j];
                cv_reg[j]  <= cv_next[j];
            end
        end
    end

    assign trig.sin_mag = sv_reg[N-1][29:0];
    assign trig.cos_mag = cv_reg[N-1];
    assign trig.quad    = q_reg[N-1];
    assign trig.neg     = neg_reg[N-1];

endmodule

FILE: hdl/chs_scale.sv
// Quadrant rotation, radius scaling, rounding and saturation of the x and y components.
module chs_scale (
    input  logic                             aclk,
    input  logic [chs_pkg::SCALE_STAGES-1:0] stage_en,
    input  chs_pkg::trig_t                   trig,
    input  logic [14:0]                      radius,
    output logic signed [15:0]               dir_x,
    output logic signed [15:0]               dir_y
);

    function automatic logic [15:0] round_sat(input logic [45:0] prod, input logic neg);
        logic [45:0] sum;
        logic [15:0] mag;
        sum = prod + chs_pkg::HALF_Q30;
        mag = 16'(sum >> 30);
        if (mag > chs_pkg::SAT_LIM) begin
            mag = chs_pkg::SAT_LIM;
        end
        return neg ? (16'd0 - mag) : mag;
    endfunction

    logic [30:0] cm;
    logic [30:0] sm;
    logic        cn;
    logic        sn;

    logic [45:0] prod_x_reg;
    logic [45:0] prod_y_reg;
    logic        neg_x_reg;
    logic        neg_y_reg;
    logic [15:0] dir_x_reg;
    logic [15:0] dir_y_reg;

    always_comb begin
        cm = trig.cos_mag;
        sm = 31'(trig.sin_mag);
        cn = 1'b0;
        sn = trig.neg;
        case (trig.quad)
            chs_pkg::QUAD_EAST: begin
                cm = trig.cos_mag;
                cn = 1'b0;
                sm = 31'(trig.sin_mag);
                sn = trig.neg;
            end
            chs_pkg::QUAD_NORTH: begin
                cm = 31'(trig.sin_mag);
                cn = !trig.neg;
                sm = trig.cos_mag;
                sn = 1'b0;
            end
            chs_pkg::QUAD_WEST: begin
                cm = trig.cos_mag;
                cn = 1'b1;
                sm = 31'(trig.sin_mag);
                sn = !trig.neg;
            end
            chs_pkg::QUAD_SOUTH: begin
                cm = 31'(trig.sin_mag);
                cn = trig.neg;
                sm = trig.cos_mag;
                sn = 1'b1;
            end
            default: begin
                cm = trig.cos_mag;
                cn = 1'b0;
                sm = 31'(trig.sin_mag);
                sn = trig.neg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            prod_x_reg <= 46'(radius) * 46'(cm);
            prod_y_reg <= 46'(radius) * 46'(sm);
            neg_x_reg  <= cn;
            neg_y_reg  <= sn;
        end
        if (stage_en[1]) begin
            dir_x_reg <= round_sat(prod_x_reg, neg_x_reg);
            dir_y_reg <= round_sat(prod_y_reg, neg_y_reg);
        end
    end

    assign dir_x = $signed(dir_x_reg);
    assign dir_y = $signed(dir_y_reg);

endmodule

FILE: hdl/cosine_hemisphere_sampler.sv
// Top level of the cosine-weighted hemisphere direction sampler.
//
// Input channel (s_valid / s_ready): one transaction carries two uniform
// fractions, s_radial_uniform and s_angle_uniform, each value / 65536.
// Output channel (m_valid / m_ready): one transaction per input, carrying the
// unit direction m_dir_x, m_dir_y (signed Q1.15, saturated to +-32767) and
// m_dir_z (unsigned Q1.15, 32768 is 1.0).
// The datapath is a 13-stage pipeline; unless every stage is full and m_ready
// is low, one transaction is accepted per cycle. The depth is set by the
// Horner chain of the sine/cosine series, which alternates a t^2 multiply
// stage and a reciprocal-divide stage.
// The square roots run alongside in four stages, four root bits per stage.
// Reset (aresetn low, synchronous) empties every stage; the block keeps no
// other state. When the receiver holds m_ready low, the result stays on the
// output register and stages behind it keep filling empty slots, so s_ready
// drops only once every stage holds a transaction.
module cosine_hemisphere_sampler (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_radial_uniform,
    input  logic [15:0]        s_angle_uniform,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_dir_x,
    output logic signed [15:0] m_dir_y,
    output logic [15:0]        m_dir_z
);

    localparam int LAST       = chs_pkg::NUM_STAGES - 1;
    localparam int DELAY_BASE = chs_pkg::STAGE_SQRT_LAST + 1;

    logic [chs_pkg::NUM_STAGES-1:0] valid_reg;
    logic [chs_pkg::NUM_STAGES-1:0] valid_next;
    logic [chs_pkg::NUM_STAGES-1:0] stage_en;

    logic [15:0] u1_reg;
    logic [15:0] u2_reg;
    logic [16:0] z_diff;
    logic [31:0] r_val;
    logic [31:0] z_val;
    logic [15:0] r_root;
    logic [15:0] z_root;

    logic [14:0] rad_reg [DELAY_BASE:chs_pkg::STAGE_TRIG_LAST];
    logic [15:0] zd_reg  [DELAY_BASE:LAST];

    chs_pkg::trig_t trig;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        stage_en[LAST] = !valid_reg[LAST] || m_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign valid_next = {valid_reg[LAST-1:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < chs_pkg::NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            u1_reg <= s_radial_uniform;
            u2_reg <= s_angle_uniform;
        end
    end

    // Both roots are taken of a fraction rescaled from 2^16 to 2^30.
    assign z_diff = 17'h10000 - {1'b0, u1_reg};
    assign r_val  = {2'b00, u1_reg, 14'd0};
    assign z_val  = {1'b0, z_diff, 14'd0};

    chs_isqrt u_sqrt_r (
        .aclk     (aclk),
        .stage_en (stage_en[chs_pkg::STAGE_SQRT_LAST:1]),
        .value    (r_val),
        .root     (r_root)
    );

    chs_isqrt u_sqrt_z (
        .aclk     (aclk),
        .stage_en (stage_en[chs_pkg::STAGE_SQRT_LAST:1]),
        .value    (z_val),
        .root     (z_root)
    );

    chs_sincos u_sincos (
        .aclk     (aclk),
        .stage_en (stage_en[chs_pkg::STAGE_TRIG_LAST:1]),
        .angle    (u2_reg),
        .trig     (trig)
    );

    // Radius waits for the series; z waits for the output stage.
    always_ff @(posedge aclk) begin
        if (stage_en[DELAY_BASE]) begin
            rad_reg[DELAY_BASE] <= r_root[14:0];
            zd_reg[DELAY_BASE]  <= z_root;
        end
        for (int k = DELAY_BASE + 1; k <= chs_pkg::STAGE_TRIG_LAST; k++) begin
            if (stage_en[k]) begin
                rad_reg[k] <= rad_reg[k-1];
            end
        end
        for (int k = DELAY_BASE + 1; k <= LAST; k++) begin
            if (stage_en[k]) begin
                zd_reg[k] <= zd_reg[k-1];
            end
        end
    end

    chs_scale u_scale (
        .aclk     (aclk),
        .stage_en (stage_en[LAST:chs_pkg::STAGE_SCALE_FIRST]),
        .trig     (trig),
        .radius   (rad_reg[chs_pkg::STAGE_TRIG_LAST]),
        .dir_x    (m_dir_x),
        .dir_y    (m_dir_y)
    );

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[LAST];
    assign m_dir_z = zd_reg[LAST];

endmodule

FILE: tb/tb_cosine_hemisphere_sampler.sv
// Self-checking testbench for the cosine hemisphere sampler with a fixed-point direction predictor.
`timescale 1ns / 1ps

module tb_cosine_hemisphere_sampler;

    localparam int UNI_BITS  = 16;
    localparam int FRAC_BITS = 15;
    localparam longint unsigned UNIT_Q30 = 64'd1 << 30;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        z;
    } dir_t;

    class direction_scoreboard;
        dir_t pending_dirs[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        function longint unsigned root_u64(longint unsigned v);
            longint unsigned res;
            longint unsigned probe;
            res   = 0;
            probe = 64'd1 << 62;
            while (probe > v) probe >>= 2;
            while (probe != 0) begin
                if (v >= res + probe) begin
                    v   -= res + probe;
                    res  = (res >> 1) + probe;
                end else begin
                    res >>= 1;
                end
                probe >>= 2;
            end
            return res;
        endfunction

        // Rescales a fraction of 2^UNI_BITS to a fraction of 2^(2*FRAC_BITS).
        function longint unsigned to_frac_sq(longint unsigned v);
            int shift;
            shift = 2 * FRAC_BITS - UNI_BITS;
            if (shift >= 0) return v << shift;
            return v >> (-shift);
        endfunction

        function longint unsigned horner_step(longint unsigned t2, longint unsigned h,
                                              longint unsigned k);
            return UNIT_Q30 - ((t2 * h) >> 30) / k;
        endfunction

        function logic [15:0] scale_mag(longint unsigned rad, longint unsigned mag, bit neg);
            longint unsigned p;
            p = (rad * mag + (64'd1 << 29)) >> 30;
            if (p > (64'd1 << FRAC_BITS) - 1) p = (64'd1 << FRAC_BITS) - 1;
            if (neg) p = 64'd0 - p;
            return p[15:0];
        endfunction

        function dir_t predict_direction(logic [15:0] radial, logic [15:0] angle);
            longint unsigned rad, zq, turn, resid, emag, t, t2, h, s, c, cm, sm;
            logic [1:0] quad;
            bit eneg, cn, sn;
            dir_t d;
            rad  = root_u64(to_frac_sq(64'(radial)));
            zq   = root_u64(to_frac_sq((64'd1 << UNI_BITS) - 64'(radial)));
            turn = (64'(angle) << (32 - UNI_BITS)) & 64'hFFFF_FFFF;
            quad = 2'((turn + (64'd1 << 29)) >> 30);
            // Residual angle is a signed 32-bit fraction of a turn around the quadrant axis.
            resid = (turn - (64'(quad) << 30)) & 64'hFFFF_FFFF;
            eneg  = resid >= (64'd1 << 31);
            emag  = eneg ? (64'd1 << 32) - resid : resid;
            t     = (emag * 64'(chs_pkg::TWO_PI_Q29)) >> 31;
            t2    = (t * t) >> 30;

            h = UNIT_Q30 - t2 / 72;
            h = horner_step(t2, h, 42);
            h = horner_step(t2, h, 20);
            h = horner_step(t2, h, 6);
            s = (t * h) >> 30;

            h = UNIT_Q30 - t2 / 90;
            h = horner_step(t2, h, 56);
            h = horner_step(t2, h, 30);
            h = horner_step(t2, h, 12);
            c = horner_step(t2, h, 2);

            case (quad)
                chs_pkg::QUAD_EAST: begin
                    cm = c; cn = 1'b0; sm = s; sn = eneg;
                end
                chs_pkg::QUAD_NORTH: begin
                    cm = s; cn = !eneg; sm = c; sn = 1'b0;
                end
                chs_pkg::QUAD_WEST: begin
                    cm = c; cn = 1'b1; sm = s; sn = !eneg;
                end
                default: begin
                    cm = s; cn = eneg; sm = c; sn = 1'b1;
                end
            endcase

            d.x = scale_mag(rad, cm, cn);
            d.y = scale_mag(rad, sm, sn);
            d.z = zq[15:0];
            return d;
        endfunction

        function void note_input(logic [15:0] radial, logic [15:0] angle);
            pending_dirs.push_back(predict_direction(radial, angle));
        endfunction

        task report(string what);
            if (mismatches < 100) $display("%0t MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic signed [15:0] x, logic signed [15:0] y, logic [15:0] z);
            dir_t exp_dir;
            if (pending_dirs.size() == 0) begin
                report($sformatf("unexpected result x=%0d y=%0d z=%0d", x, y, z));
                return;
            end
            exp_dir = pending_dirs.pop_front();
            if (x !== exp_dir.x)
                report($sformatf("dir_x got %0d, want %0d", x, exp_dir.x));
            if (y !== exp_dir.y)
                report($sformatf("dir_y got %0d, want %0d", y, exp_dir.y));
            if (z !== exp_dir.z)
                report($sformatf("dir_z got %0d, want %0d", z, exp_dir.z));
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [15:0]        s_radial_uniform = '0;
    logic [15:0]        s_angle_uniform = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_dir_x;
    logic signed [15:0] m_dir_y;
    logic [15:0]        m_dir_z;

    int send_idle_pct = 33;
    int recv_idle_pct = 68;

    direction_scoreboard sb;

    int unsigned radial_corners[4] = '{0, 1, 32768, 65535};
    int unsigned angle_corners[6]  = '{0, 8192, 16384, 32768, 49152, 65535};

    cosine_hemisphere_sampler dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_radial_uniform (s_radial_uniform),
        .s_angle_uniform  (s_angle_uniform),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_dir_x          (m_dir_x),
        .m_dir_y          (m_dir_y),
        .m_dir_z          (m_dir_z)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Enters and leaves right after a rising edge; holds the payload until accepted.
    task send_pair(input logic [15:0] radial, input logic [15:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_radial_uniform <= radial;
        s_angle_uniform  <= angle;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(radial, angle);
    endtask

    initial begin
        do @(posedge aclk); while (!aresetn);
        forever begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_dir_x, m_dir_y, m_dir_z);
        end
    end

    initial begin
        logic [15:0] radial;
        logic [15:0] angle;
        int          tail;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corners: zero and full radius, every quadrant axis and an octant edge.
        foreach (radial_corners[i])
            foreach (angle_corners[j])
                send_pair(radial_corners[i][15:0], angle_corners[j][15:0]);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 33 : 0;
            repeat (225) begin
                radial = 16'($urandom);
                angle  = 16'($urandom);
                case ($urandom_range(3))
                    2: radial = $urandom_range(1) ? 16'($urandom_range(3))
                                                  : 16'(65535 - $urandom_range(3));
                    // Near octant boundaries the quadrant and residual sign flip.
                    3: angle = 16'($urandom_range(7) * 8192 + $urandom_range(2) - 1);
                    default: ;
                endcase
                send_pair(radial, angle);
            end
        end
        s_valid <= 1'b0;

        while (sb.pending_dirs.size() != 0) @(posedge aclk);
        for (tail = 0; tail < 30; tail++) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending_dirs.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
hdl/chs_pkg.sv
hdl/chs_isqrt.sv
hdl/chs_sincos.sv
hdl/chs_scale.sv
hdl/cosine_hemisphere_sampler.sv
tb/tb_cosine_hemisphere_sampler.sv
